### rtl/ppfa_pkg.sv
`timescale 1ns / 1ps

package ppfa_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int FRAME_BYTES   = 262144;
  localparam int PALETTE_DEPTH = 256;

  localparam int FRAME_AW = $clog2(FRAME_BYTES);
  localparam int FRAME_DW = 9;                 // {written flag, byte}
  localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
  localparam int X_W      = $clog2(MAX_WIDTH);
  localparam int Y_W      = $clog2(MAX_HEIGHT);
  localparam int RL_W     = $clog2(3 * MAX_WIDTH + 4);
  localparam int CALC_W   = Y_W + RL_W + 1;
  localparam int CFG_AW   = 5;

  typedef enum logic [1:0] {
    DEPTH_1  = 2'd0,
    DEPTH_4  = 2'd1,
    DEPTH_8  = 2'd2,
    DEPTH_24 = 2'd3
  } ppfa_depth_t;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_PAL   = 2'd2
  } ppfa_req_t;

  typedef enum logic [2:0] {
    REG_DEPTH    = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_PAL_LEN  = 3'd3,
    REG_TOP_DOWN = 3'd4,
    REG_FILL     = 3'd5,
    REG_WR_EN    = 3'd6
  } ppfa_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_MUL,
    S_ADDR,
    S_RD,
    S_RMW,
    S_PAL,
    S_PALD,
    S_DONE
  } ppfa_state_t;

  typedef struct packed {
    ppfa_depth_t depth_mode;
    logic [8:0]  width;
    logic [8:0]  height;
    logic [8:0]  pal_len;
    logic        top_down;
    logic [7:0]  fill;
    logic        wr_en;
  } ppfa_cfg_t;

endpackage

### rtl/ppfa_ram.sv
`timescale 1ns / 1ps

module ppfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ppfa_cfg.sv
`timescale 1ns / 1ps

module ppfa_cfg
  import ppfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output ppfa_cfg_t         cfg
);

  ppfa_cfg_t cfg_r;
  ppfa_reg_t reg_idx;
  logic      wr_stb;

  assign reg_idx = ppfa_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_stb  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode <= DEPTH_24;
      cfg_r.width      <= 9'd256;
      cfg_r.height     <= 9'd256;
      cfg_r.pal_len    <= 9'd0;
      cfg_r.top_down   <= 1'b0;
      cfg_r.fill       <= 8'hFF;
      cfg_r.wr_en      <= 1'b1;
    end else if (wr_stb) begin
      case (reg_idx)
        REG_DEPTH:    cfg_r.depth_mode <= ppfa_depth_t'(pwdata[1:0]);
        REG_WIDTH:    cfg_r.width      <= pwdata[8:0];
        REG_HEIGHT:   cfg_r.height     <= pwdata[8:0];
        REG_PAL_LEN:  cfg_r.pal_len    <= pwdata[8:0];
        REG_TOP_DOWN: cfg_r.top_down   <= pwdata[0];
        REG_FILL:     cfg_r.fill       <= pwdata[7:0];
        REG_WR_EN:    cfg_r.wr_en      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEPTH:    prdata = {30'd0, cfg_r.depth_mode};
      REG_WIDTH:    prdata = {23'd0, cfg_r.width};
      REG_HEIGHT:   prdata = {23'd0, cfg_r.height};
      REG_PAL_LEN:  prdata = {23'd0, cfg_r.pal_len};
      REG_TOP_DOWN: prdata = {31'd0, cfg_r.top_down};
      REG_FILL:     prdata = {24'd0, cfg_r.fill};
      REG_WR_EN:    prdata = {31'd0, cfg_r.wr_en};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### rtl/packed_pixel_frame_access.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// in_       in   in_tvalid/tready   tdata: pos_x, pos_y, color_value, palette_slot
//                                   tuser: req_type, use_index
// out_      out  out_tvalid/tready  tdata: pixel_value; tuser: access_error
// config    in   APB psel/penable   7 registers at byte address 4*i
//
// One request at a time. Accept (S_IDLE), range check (S_CALC), row multiply (S_MUL)
// and address (S_ADDR), then a read and a read-modify-write state per frame byte on the
// single frame memory port (1 byte, or 3 at 24 bpp), a palette lookup (S_PAL, S_PALD)
// when needed and S_DONE to post the result. Palette loads and failed requests go to S_DONE early.
// After reset a clearing pass over all FRAME_BYTES (262144) frame bytes marks
// every frame byte unwritten; no request is taken meanwhile.
// A finished result waits in the output register while the next request runs;
// a request stalls only when its own result finds that register still full.
module packed_pixel_frame_access
  import ppfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [15:0] pos_x, [31:16] pos_y, [55:32] color_value, [63:56] palette_slot
  input  logic [63:0]       in_tdata,
  // [1:0] req_type, [2] use_index
  input  logic [2:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [23:0] pixel_value
  output logic [23:0]       out_tdata,
  // [0] access_error
  output logic              out_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ppfa_cfg_t   cfg;
  ppfa_state_t state_r, state_nxt;

  // request fields
  logic [1:0]  req_r;
  logic [15:0] x_r, y_r;
  logic [23:0] color_r;
  logic        use_idx_r;
  logic [7:0]  slot_r;

  logic [FRAME_AW-1:0] clr_cnt_r;
  logic [Y_W-1:0]      y_eff_r;
  logic [RL_W-1:0]     rl_r;
  logic [CALC_W-1:0]   base_r;
  logic [FRAME_AW-1:0] addr_r;
  logic [1:0]          k_r;
  logic [7:0]          idx_r;
  logic [23:0]         res_r;
  logic                err_r;
  logic [PALETTE_DEPTH-1:0] pal_valid_r;

  logic                out_tvalid_r;
  logic [23:0]         out_data_r;
  logic                out_err_r;

  // memory ports
  logic [FRAME_AW-1:0] frame_addr;
  logic                frame_we;
  logic [FRAME_DW-1:0] frame_wdata, frame_rdata;
  logic [PAL_AW-1:0]   pal_addr;
  logic                pal_we;
  logic [23:0]         pal_rdata;
  logic                load_out;

  ppfa_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  assign pready = 1'b1;

  ppfa_ram #(.WIDTH(FRAME_DW), .DEPTH(FRAME_BYTES)) u_frame_ram (
    .clk  (clk),
    .addr (frame_addr),
    .we   (frame_we),
    .wdata(frame_wdata),
    .rdata(frame_rdata)
  );

  ppfa_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
    .clk  (clk),
    .addr (pal_addr),
    .we   (pal_we),
    .wdata(color_r),
    .rdata(pal_rdata)
  );

  // ---------------- range check and row length ----------------
  logic [15:0] w_eff, h_eff, y_flip, rl_full;
  logic        coord_bad, wr_bad, pix_req, calc_err;

  assign w_eff  = ({7'd0, cfg.width} > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : {7'd0, cfg.width};
  assign h_eff  = ({7'd0, cfg.height} > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : {7'd0, cfg.height};
  assign y_flip = cfg.top_down ? y_r : (h_eff - 16'd1 - y_r);

  assign coord_bad = x_r[15] || y_r[15] || (x_r >= w_eff) || (y_r >= h_eff);
  assign wr_bad    = (req_r == REQ_WRITE) &&
                     (!cfg.wr_en ||
                      (!use_idx_r && (cfg.depth_mode == DEPTH_4 || cfg.depth_mode == DEPTH_8)));
  assign pix_req   = (req_r == REQ_READ) || (req_r == REQ_WRITE);
  assign calc_err  = (req_r == REQ_PAL) ? (32'(slot_r) >= 32'(PALETTE_DEPTH))
                                        : (!pix_req || coord_bad || wr_bad);

  always_comb begin
    case (cfg.depth_mode)
      DEPTH_1:  rl_full = (((w_eff + 16'd7) >> 3) + 16'd3) & ~16'd3;
      DEPTH_4:  rl_full = (((w_eff + 16'd1) >> 1) + 16'd3) & ~16'd3;
      DEPTH_8:  rl_full = (w_eff + 16'd3) & ~16'd3;
      default:  rl_full = ((w_eff + w_eff + w_eff) + 16'd3) & ~16'd3;
    endcase
  end

  // ---------------- byte address ----------------
  logic [X_W+1:0]    x_off;
  logic [CALC_W-1:0] addr_calc, last_calc;
  logic              ovf;

  always_comb begin
    case (cfg.depth_mode)
      DEPTH_1:  x_off = (X_W+2)'(x_r[X_W-1:0] >> 3);
      DEPTH_4:  x_off = (X_W+2)'(x_r[X_W-1:0] >> 1);
      DEPTH_8:  x_off = (X_W+2)'(x_r[X_W-1:0]);
      default:  x_off = (X_W+2)'(x_r[X_W-1:0]) + (X_W+2)'({x_r[X_W-1:0], 1'b0});
    endcase
  end

  assign addr_calc = base_r + CALC_W'(x_off);
  assign last_calc = addr_calc + ((cfg.depth_mode == DEPTH_24) ? CALC_W'(2) : CALC_W'(0));
  assign ovf       = 32'(last_calc) >= 32'(FRAME_BYTES);

  // ---------------- byte modify ----------------
  logic [7:0] cur_byte, new_byte, bit_mask, ext_val;
  logic [1:0] last_k;
  logic       is_write, map_needed, pal_hit;
  logic [8:0] pal_len_eff;

  assign cur_byte = frame_rdata[8] ? frame_rdata[7:0] : cfg.fill;
  assign bit_mask = 8'h80 >> x_r[2:0];
  assign last_k   = (cfg.depth_mode == DEPTH_24) ? 2'd2 : 2'd0;
  assign is_write = (req_r == REQ_WRITE);
  assign map_needed = is_write ? (cfg.depth_mode == DEPTH_4 || cfg.depth_mode == DEPTH_8)
                               : (cfg.depth_mode != DEPTH_24 && !use_idx_r);

  always_comb begin
    case (cfg.depth_mode)
      DEPTH_1:  ext_val = {7'd0, cur_byte[3'd7 - x_r[2:0]]};
      DEPTH_4:  ext_val = x_r[0] ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]};
      default:  ext_val = cur_byte;
    endcase
  end

  always_comb begin
    case (cfg.depth_mode)
      DEPTH_1:  new_byte = (color_r != 24'd0) ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
      DEPTH_4:  new_byte = x_r[0] ? {cur_byte[7:4], color_r[3:0]}
                                  : {color_r[3:0], cur_byte[3:0]};
      DEPTH_8:  new_byte = color_r[7:0];
      default: begin
        case (k_r)
          2'd0:    new_byte = color_r[7:0];
          2'd1:    new_byte = color_r[15:8];
          default: new_byte = color_r[23:16];
        endcase
      end
    endcase
  end

  // an index inside the palette maps to its entry; an entry never loaded reads as zero
  assign pal_len_eff = (cfg.pal_len > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : cfg.pal_len;
  assign pal_hit     = ({1'b0, idx_r} < pal_len_eff);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == FRAME_AW'(FRAME_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_CALC;
      S_CALC:  state_nxt = (calc_err || req_r == REQ_PAL) ? S_DONE : S_MUL;
      S_MUL:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = ovf ? S_DONE : S_RD;
      S_RD:    state_nxt = S_RMW;
      S_RMW: begin
        if (k_r != last_k) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = map_needed ? S_PAL : S_DONE;
        end
      end
      S_PAL:   state_nxt = S_PALD;
      S_PALD:  state_nxt = S_DONE;
      S_DONE:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_tready   = 1'b0;
    frame_addr  = addr_r + FRAME_AW'(k_r);
    frame_we    = 1'b0;
    frame_wdata = {1'b1, new_byte};
    pal_addr    = idx_r[PAL_AW-1:0];
    pal_we      = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        frame_addr  = clr_cnt_r;
        frame_we    = 1'b1;
        frame_wdata = '0;
      end
      S_IDLE:  in_tready = 1'b1;
      S_CALC: begin
        pal_addr = slot_r[PAL_AW-1:0];
        pal_we   = (req_r == REQ_PAL) && !calc_err;
      end
      S_RMW:   frame_we = is_write;
      S_DONE:  load_out = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      pal_valid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + FRAME_AW'(1);
      end
      if (pal_we) begin
        pal_valid_r[pal_addr] <= 1'b1;
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r     <= in_tuser[1:0];
        use_idx_r <= in_tuser[2];
        x_r       <= in_tdata[15:0];
        y_r       <= in_tdata[31:16];
        color_r   <= in_tdata[55:32];
        slot_r    <= in_tdata[63:56];
      end
      S_CALC: begin
        y_eff_r <= y_flip[Y_W-1:0];
        rl_r    <= rl_full[RL_W-1:0];
        k_r     <= 2'd0;
        err_r   <= calc_err;
        res_r   <= (calc_err || req_r != REQ_PAL) ? 24'd0 : color_r;
      end
      S_MUL:   base_r <= CALC_W'(y_eff_r * rl_r);
      S_ADDR: begin
        addr_r <= FRAME_AW'(addr_calc);
        err_r  <= ovf;
      end
      S_RMW: begin
        k_r <= k_r + 2'd1;
        if (is_write) begin
          res_r <= color_r;
          idx_r <= (cfg.depth_mode == DEPTH_4) ? {4'd0, color_r[3:0]} : color_r[7:0];
        end else if (cfg.depth_mode == DEPTH_24) begin
          case (k_r)
            2'd0:    res_r[7:0]   <= cur_byte;
            2'd1:    res_r[15:8]  <= cur_byte;
            default: res_r[23:16] <= cur_byte;
          endcase
        end else begin
          res_r <= {16'd0, ext_val};
          idx_r <= ext_val;
        end
      end
      S_PALD: begin
        if (pal_hit) begin
          res_r <= pal_valid_r[idx_r[PAL_AW-1:0]] ? pal_rdata : 24'd0;
        end else begin
          res_r <= {16'd0, idx_r};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_data_r <= err_r ? 24'd0 : res_r;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // ---------------- checks ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("failed access carries a non-zero pixel");

  a_req_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    frame_we && state_r != S_CLEAR |-> frame_wdata[8] && is_write && cfg.wr_en && !err_r)
    else $error("frame byte written outside an allowed pixel write");

  a_pal_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |-> req_r == REQ_PAL && state_r == S_CALC)
    else $error("palette written by a non-load request");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RMW && cfg.depth_mode != DEPTH_24 |-> k_r == 2'd0)
    else $error("extra byte access at a sub-word depth");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> $past(state_r) != S_CLEAR || clr_cnt_r == '0)
    else $error("request taken before the clearing pass ended");

endmodule

### tb/packed_pixel_frame_access_tb.sv
`timescale 1ns / 1ps

module packed_pixel_frame_access_tb;
  import ppfa_pkg::*;

  localparam bit [1:0] REQ_NONE = 2'd3;       // undefined request code
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    bit [23:0] pixel;
    bit        err;
  } px_result_t;

  class pixel_result_board;
    bit [7:0]   frame_mem [FRAME_BYTES];
    bit         byte_valid [FRAME_BYTES];
    bit [23:0]  palette [PALETTE_DEPTH];
    ppfa_cfg_t  cfg;
    px_result_t pending_pixels [$];
    int         fail_count;

    function new();
      cfg.depth_mode = DEPTH_24;
      cfg.width      = 9'd256;
      cfg.height     = 9'd256;
      cfg.pal_len    = 9'd0;
      cfg.top_down   = 1'b0;
      cfg.fill       = 8'hFF;
      cfg.wr_en      = 1'b1;
      fail_count     = 0;
    endfunction

    function void set_reg(ppfa_reg_t r, bit [31:0] v);
      case (r)
        REG_DEPTH:    cfg.depth_mode = ppfa_depth_t'(v[1:0]);
        REG_WIDTH:    cfg.width      = v[8:0];
        REG_HEIGHT:   cfg.height     = v[8:0];
        REG_PAL_LEN:  cfg.pal_len    = v[8:0];
        REG_TOP_DOWN: cfg.top_down   = v[0];
        REG_FILL:     cfg.fill       = v[7:0];
        REG_WR_EN:    cfg.wr_en      = v[0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      return cfg.width > MAX_WIDTH ? MAX_WIDTH : cfg.width;
    endfunction

    function int eff_height();
      return cfg.height > MAX_HEIGHT ? MAX_HEIGHT : cfg.height;
    endfunction

    function int stored_byte(int a);
      return byte_valid[a] ? frame_mem[a] : cfg.fill;
    endfunction

    function void store_byte(int a, int v);
      frame_mem[a]  = v[7:0];
      byte_valid[a] = 1'b1;
    endfunction

    function bit [23:0] palette_colour(int idx);
      int len;
      len = cfg.pal_len > PALETTE_DEPTH ? PALETTE_DEPTH : cfg.pal_len;
      if (len != 0 && idx < len) return palette[idx];
      return idx[23:0];
    endfunction

    function void note_request(bit [1:0] req, bit [15:0] px, bit [15:0] py,
                               bit [23:0] colour, bit use_idx, bit [7:0] slot);
      px_result_t r;
      int w, h, x, y, rl, addr, last, b, nib, bitmask;
      r.pixel = 24'd0;
      r.err   = 1'b1;
      w = eff_width();
      h = eff_height();
      if (req == REQ_PAL) begin
        palette[slot] = colour;
        r.pixel = colour;
        r.err   = 1'b0;
      end else if ((req == REQ_READ || req == REQ_WRITE) &&
                   !px[15] && !py[15] && px < w && py < h) begin
        x = px;
        y = cfg.top_down ? int'(py) : h - 1 - int'(py);
        case (cfg.depth_mode)
          DEPTH_1:  begin rl = ((w + 7) / 8 + 3) / 4 * 4; addr = y * rl + (x >> 3); end
          DEPTH_4:  begin rl = ((w + 1) / 2 + 3) / 4 * 4; addr = y * rl + (x >> 1); end
          DEPTH_8:  begin rl = (w + 3) / 4 * 4;           addr = y * rl + x;        end
          default:  begin rl = (3 * w + 3) / 4 * 4;       addr = y * rl + 3 * x;    end
        endcase
        last = (cfg.depth_mode == DEPTH_24) ? addr + 2 : addr;
        if (last < FRAME_BYTES) begin
          if (req == REQ_READ) begin
            b = stored_byte(addr);
            r.err = 1'b0;
            case (cfg.depth_mode)
              DEPTH_1: b = (b >> (7 - (x & 7))) & 1;
              DEPTH_4: b = (x & 1) ? (b & 'h0F) : (b >> 4);
              default: ;
            endcase
            if (cfg.depth_mode == DEPTH_24)
              r.pixel = 24'(b | (stored_byte(addr + 1) << 8) | (stored_byte(addr + 2) << 16));
            else
              r.pixel = use_idx ? b[23:0] : palette_colour(b);
          end else if (cfg.wr_en) begin
            case (cfg.depth_mode)
              DEPTH_1: begin
                bitmask = 'h80 >> (x & 7);
                b = stored_byte(addr);
                b = (colour != 0) ? (b | bitmask) : (b & ~bitmask & 'hFF);
                store_byte(addr, b);
                r.pixel = colour;
                r.err   = 1'b0;
              end
              DEPTH_4: if (use_idx) begin
                nib = colour & 'h0F;
                b = stored_byte(addr);
                b = (x & 1) ? ((b & 'hF0) | nib) : ((b & 'h0F) | (nib << 4));
                store_byte(addr, b);
                r.pixel = palette_colour(nib);
                r.err   = 1'b0;
              end
              DEPTH_8: if (use_idx) begin
                store_byte(addr, colour & 'hFF);
                r.pixel = palette_colour(colour & 'hFF);
                r.err   = 1'b0;
              end
              default: begin
                store_byte(addr, colour[7:0]);
                store_byte(addr + 1, colour[15:8]);
                store_byte(addr + 2, colour[23:16]);
                r.pixel = colour;
                r.err   = 1'b0;
              end
            endcase
          end
        end
      end
      pending_pixels.push_back(r);
    endfunction

    function void check_result(bit [23:0] pixel, bit err);
      px_result_t e;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result pixel=%06h err=%0b", $time, pixel, err);
        fail_count++;
        return;
      end
      e = pending_pixels.pop_front();
      if (pixel != e.pixel) begin
        $display("%0t: pixel_value expected %06h actual %06h", $time, e.pixel, pixel);
        fail_count++;
      end
      if (err != e.err) begin
        $display("%0t: access_error expected %0b actual %0b", $time, e.err, err);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;
  logic [2:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;
  logic              out_tuser;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  pixel_result_board board = new();
  bit idling_on = 1'b1;
  int long_hold_req = 0;
  int cycle_count = 0;

  packed_pixel_frame_access u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req > 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input bit [1:0] req, input bit [15:0] px, input bit [15:0] py,
                              input bit [23:0] colour, input bit use_idx,
                              input bit [7:0] slot);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {slot, colour, py, px};
    in_tuser  <= {use_idx, req};
    do @(posedge clk); while (!in_tready);
    board.note_request(req, px, py, colour, use_idx, slot);
  endtask

  // drop valid and hold until every outstanding result has been taken
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_pixels.size() != 0);
  endtask

  task automatic write_reg(input ppfa_reg_t r, input bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_reg(r, v);
  endtask

  task automatic set_frame_config(input ppfa_depth_t d, input int w, input int h,
                                  input int pl, input bit td, input bit [7:0] fill,
                                  input bit we);
    wait_idle();
    write_reg(REG_DEPTH, d);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PAL_LEN, pl);
    write_reg(REG_TOP_DOWN, td);
    write_reg(REG_FILL, fill);
    write_reg(REG_WR_EN, we);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int kind, w, h;
    bit [1:0]  req;
    bit [15:0] px, py;
    bit [23:0] colour;
    bit        use_idx;
    w = board.eff_width();
    h = board.eff_height();
    kind    = $urandom_range(0, 99);
    colour  = 24'($urandom_range(0, 24'hFFFFFF));
    use_idx = 1'($urandom_range(0, 1));
    if (kind < 12) req = REQ_PAL;
    else if (kind < 16) req = REQ_NONE;
    else if (kind < 58) req = REQ_READ;
    else req = REQ_WRITE;
    // mostly valid coordinates, the rest on the border or anywhere
    case ($urandom_range(0, 19))
      0: begin
        px = 16'($urandom_range(0, 16'hFFFF));
        py = 16'($urandom_range(0, 16'hFFFF));
      end
      1:       begin px = 16'(w); py = 16'($urandom_range(0, h - 1)); end
      2:       begin px = 16'($urandom_range(0, w - 1)); py = 16'hFFFF; end
      default: begin px = 16'($urandom_range(0, w - 1)); py = 16'($urandom_range(0, h - 1)); end
    endcase
    if (req == REQ_WRITE && $urandom_range(0, 9) != 0) use_idx = 1'b1;
    if (board.cfg.depth_mode == DEPTH_1 && $urandom_range(0, 1)) colour = 24'd0;
    send_request(req, px, py, colour, use_idx, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int w, h, pl, n;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 24 bpp, full frame, unwritten bytes read as fill
    send_request(REQ_READ, 16'd0, 16'd0, 24'h0, 1'b0, 8'd0);
    send_request(REQ_WRITE, 16'd0, 16'd0, 24'h123456, 1'b0, 8'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 24'h0, 1'b0, 8'd0);
    send_request(REQ_WRITE, 16'd255, 16'd255, 24'hFFFFFF, 1'b1, 8'hFF);
    send_request(REQ_READ, 16'd255, 16'd255, 24'h0, 1'b0, 8'd0);
    send_request(REQ_READ, 16'd256, 16'd0, 24'h0, 1'b0, 8'd0);
    send_request(REQ_READ, 16'hFFFF, 16'd0, 24'h0, 1'b0, 8'd0);
    send_request(REQ_WRITE, 16'd0, 16'h8000, 24'hFFFFFF, 1'b0, 8'd0);
    send_request(REQ_NONE, 16'h7FFF, 16'h7FFF, 24'hFFFFFF, 1'b1, 8'hFF);
    send_request(REQ_PAL, 16'd0, 16'd0, 24'hFFFFFF, 1'b0, 8'd0);
    send_request(REQ_PAL, 16'd0, 16'd0, 24'h000000, 1'b0, 8'hFF);

    // 1 bpp with a two-entry palette, rows top-down
    set_frame_config(DEPTH_1, 9, 2, 2, 1'b1, 8'hA5, 1'b1);
    send_request(REQ_PAL, 16'd0, 16'd0, 24'hABCDEF, 1'b0, 8'd1);
    send_request(REQ_READ, 16'd8, 16'd1, 24'h0, 1'b0, 8'd0);
    send_request(REQ_WRITE, 16'd8, 16'd1, 24'h000100, 1'b0, 8'd0);
    send_request(REQ_READ, 16'd8, 16'd1, 24'h0, 1'b0, 8'd0);
    send_request(REQ_READ, 16'd8, 16'd1, 24'h0, 1'b1, 8'd0);
    send_request(REQ_WRITE, 16'd8, 16'd1, 24'h0, 1'b0, 8'd0);

    // 4 bpp: writes need index mode, colour masked to a nibble
    set_frame_config(DEPTH_4, 3, 1, 16, 1'b0, 8'h00, 1'b1);
    send_request(REQ_WRITE, 16'd1, 16'd0, 24'h00000F, 1'b0, 8'd0);
    send_request(REQ_WRITE, 16'd1, 16'd0, 24'hFFFFFE, 1'b1, 8'd0);
    send_request(REQ_READ, 16'd1, 16'd0, 24'h0, 1'b0, 8'd0);

    // 8 bpp with writes disabled; palette loads still go through
    set_frame_config(DEPTH_8, 256, 256, 256, 1'b0, 8'h3C, 1'b0);
    send_request(REQ_WRITE, 16'd5, 16'd5, 24'h000011, 1'b1, 8'd0);
    send_request(REQ_PAL, 16'd0, 16'd0, 24'h55AA55, 1'b0, 8'h3C);
    send_request(REQ_READ, 16'd5, 16'd5, 24'h0, 1'b0, 8'd0);

    for (int p = 0; p < 10; p++) begin
      w  = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 24);
      h  = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 16);
      pl = $urandom_range(0, 256);
      if (p == 1) begin w = 256; h = 256; pl = 256; end
      if (p == 2) w = 1;
      if (p == 3) h = 1;
      if (p == 0) pl = 0;
      if (p == 4) pl = 2;
      set_frame_config(ppfa_depth_t'(p < 4 ? p : $urandom_range(0, 3)), w, h, pl,
                       1'($urandom_range(0, 1)),
                       p == 0 ? 8'h00 : (p == 1 ? 8'hFF : 8'($urandom_range(0, 255))),
                       p == 6 ? 1'b0 : ($urandom_range(0, 9) != 0));
      if (p == 9) idling_on = 1'b0;
      n = 198;
      for (int i = 0; i < n; i++) begin
        if (p == 3 && i == 60) long_hold_req = LONG_HOLD;
        if (p == 5 && i == 100) wait_idle();
        random_request();
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (board.fail_count == 0 && board.pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### packed_pixel_frame_access.f
rtl/ppfa_pkg.sv
rtl/ppfa_ram.sv
rtl/ppfa_cfg.sv
rtl/packed_pixel_frame_access.sv
tb/packed_pixel_frame_access_tb.sv
